// ----- hdl/ddsr_pkg.sv -----
`default_nettype none

package ddsr_pkg;

	// Field and register widths
	localparam int LIN_W  = 12;
	localparam int ANG_W  = 16;
	localparam int REG_W  = 20;
	localparam int CMP_W  = 8;
	localparam int ADDR_W = 3;
	localparam int DATA_W = 32;

	// Internal widths of the kinematics stages
	localparam int BASE_W    = 22;               // linear speed in um/s, signed
	localparam int ANG_MAG_W = 16;               // |angular|
	localparam int AH_W      = 6;                // |angular| / 1000
	localparam int AL_W      = 10;               // |angular| % 1000
	localparam int HI_W      = 26;               // body * (|angular| / 1000)
	localparam int P_W       = 30;               // body * (|angular| % 1000)
	localparam int LO_W      = 21;               // that product / 1000
	localparam int T_W       = 26;               // turn magnitude in um/s
	localparam int RIM_W     = T_W + 1;          // signed rim speed
	localparam int MAG_W     = 26;               // |rim|
	localparam int NH_W      = 26;               // numerator after the 2^16 scale
	localparam int DIV_W     = MAG_W + CMP_W;    // widest divisor trial

	// Reciprocal multiply for |angular| / 1000 (exact up to 2^15)
	localparam int AH_PROD_W = 32;
	localparam int AH_SHIFT  = 25;
	localparam logic [AH_PROD_W-1:0] AH_RECIP = 32'd33555;

	// Reciprocal multiply for x / 1000 (exact below 2^30)
	localparam int LO_PROD_W = 61;
	localparam int LO_SHIFT  = 40;
	localparam logic [LO_PROD_W-1:0] LO_RECIP = 61'd1099511628;

	localparam logic [ANG_MAG_W-1:0]    ANG_THOUSAND = 16'd1000;
	localparam logic signed [BASE_W-1:0] MM_TO_UM    = 22'sd1000;

	// Q16 step constant: 2*pi*1e6 / (6400*16), scaled by 2^16
	localparam int NH_PROD_W = 42;
	localparam int NH_SHIFT  = 16;
	localparam logic [NH_PROD_W-1:0] RATE_Q16 = 42'd4021239;

	localparam logic [CMP_W-1:0] CMP_MAX = 8'hFF;

	// Pipeline depth: kinematics stages, then saturation check, divide steps, output
	localparam int KIN_STAGES = 8;
	localparam int DIV_STAGES = CMP_W + 2;
	localparam int PIPE_DEPTH = KIN_STAGES + DIV_STAGES;

	localparam logic [REG_W-1:0] BODY_RESET  = 20'd126000;
	localparam logic [REG_W-1:0] WHEEL_RESET = 20'd35000;

	typedef enum logic [0:0] {
		REG_BODY  = 1'b0,
		REG_WHEEL = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic [MAG_W-1:0] mag;
		logic             forward;
		logic             nonzero;
	} wheel_t;

	typedef struct packed {
		logic [CMP_W-1:0] compare;
		logic             forward;
		logic             enable;
		logic             saturated;
	} wheel_res_t;

endpackage

`default_nettype wire

// ----- hdl/ddsr_cmd_if.sv -----
`default_nettype none

interface ddsr_cmd_if;
	logic                             valid;
	logic                             ready;
	logic signed [ddsr_pkg::LIN_W-1:0] linear_mm_s;
	logic signed [ddsr_pkg::ANG_W-1:0] angular_mrad_s;

	modport source (output valid, output linear_mm_s, output angular_mrad_s, input ready);
	modport sink   (input valid, input linear_mm_s, input angular_mrad_s, output ready);
endinterface

`default_nettype wire

// ----- hdl/ddsr_res_if.sv -----
`default_nettype none

interface ddsr_res_if;
	logic                        valid;
	logic                        ready;
	logic [ddsr_pkg::CMP_W-1:0] right_compare;
	logic                        right_forward;
	logic                        right_enable;
	logic [ddsr_pkg::CMP_W-1:0] left_compare;
	logic                        left_forward;
	logic                        left_enable;
	logic                        rate_saturated;

	modport source (
		output valid, input ready,
		output right_compare, output right_forward, output right_enable,
		output left_compare, output left_forward, output left_enable,
		output rate_saturated
	);
	modport sink (
		input valid, output ready,
		input right_compare, input right_forward, input right_enable,
		input left_compare, input left_forward, input left_enable,
		input rate_saturated
	);
endinterface

`default_nettype wire

// ----- hdl/diff_drive_step_rate_top.sv -----
`default_nettype none

// Channel   Dir  Handshake       Payload
// cmd       in   valid/ready     linear_mm_s, angular_mrad_s
// res       out  valid/ready     right/left compare, forward, enable; rate_saturated
// apb       in   psel/penable    body radius at 0x0, wheel radius at 0x4
//
// One command per cycle while the output register is not stalled.
// The pipeline is 18 register stages: 8 kinematics stages plus the divider,
// a saturation check, 8 restoring steps (one quotient bit per stage) and
// the output register.
// Reset clears the valid bits and loads the radius reset values.
// When the output register is full and not taken, every stage holds.

module diff_drive_step_rate_top (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	ddsr_cmd_if.sink                           cmd,
	ddsr_res_if.source                         res,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [ddsr_pkg::ADDR_W-1:0]  paddr,
	input  wire logic [ddsr_pkg::DATA_W-1:0]  pwdata,
	output logic      [ddsr_pkg::DATA_W-1:0]  prdata,
	output logic                               pready
);

	logic [ddsr_pkg::REG_W-1:0] body_rad;
	logic [ddsr_pkg::REG_W-1:0] wheel_rad;
	logic                       adv;
	logic                       vld_s [0:ddsr_pkg::PIPE_DEPTH-1];

	ddsr_pkg::wheel_t           right_s8;
	ddsr_pkg::wheel_t           left_s8;
	logic [ddsr_pkg::NH_W-1:0]  nh_s8;
	ddsr_pkg::wheel_res_t       right_q;
	ddsr_pkg::wheel_res_t       left_q;

	ddsr_apb_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.body_rad  (body_rad),
		.wheel_rad (wheel_rad)
	);

	// Advance everything unless a finished result is waiting
	assign adv       = !vld_s[ddsr_pkg::PIPE_DEPTH-1] || res.ready;
	assign cmd.ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ddsr_pkg::PIPE_DEPTH; i++) begin
				vld_s[i] <= 1'b0;
			end
		end else if (adv) begin
			vld_s[0] <= cmd.valid;
			for (int i = 1; i < ddsr_pkg::PIPE_DEPTH; i++) begin
				vld_s[i] <= vld_s[i-1];
			end
		end
	end

	ddsr_kin u_kin (
		.clk            (clk),
		.adv            (adv),
		.linear_mm_s    (cmd.linear_mm_s),
		.angular_mrad_s (cmd.angular_mrad_s),
		.body_rad       (body_rad),
		.wheel_rad      (wheel_rad),
		.right_s8       (right_s8),
		.left_s8        (left_s8),
		.nh_s8          (nh_s8)
	);

	ddsr_div u_div_right (
		.clk      (clk),
		.adv      (adv),
		.wheel_in (right_s8),
		.nh_in    (nh_s8),
		.res_q    (right_q)
	);

	ddsr_div u_div_left (
		.clk      (clk),
		.adv      (adv),
		.wheel_in (left_s8),
		.nh_in    (nh_s8),
		.res_q    (left_q)
	);

	assign res.valid          = vld_s[ddsr_pkg::PIPE_DEPTH-1];
	assign res.right_compare  = right_q.compare;
	assign res.right_forward  = right_q.forward;
	assign res.right_enable   = right_q.enable;
	assign res.left_compare   = left_q.compare;
	assign res.left_forward   = left_q.forward;
	assign res.left_enable    = left_q.enable;
	assign res.rate_saturated = right_q.saturated || left_q.saturated;

	a_right_enable: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> (res.right_enable == (res.right_compare != '0)))
		else $error("right enable disagrees with compare");

	a_left_enable: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> (res.left_enable == (res.left_compare != '0)))
		else $error("left enable disagrees with compare");

	a_sat_clamped: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.rate_saturated |->
			(res.right_compare == ddsr_pkg::CMP_MAX || res.left_compare == ddsr_pkg::CMP_MAX))
		else $error("saturation flagged without a clamped compare");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!cmd.ready |-> (res.valid && !res.ready))
		else $error("command stalled while output is free");

endmodule

`default_nettype wire

// ----- hdl/ddsr_apb_regs.sv -----
`default_nettype none

module ddsr_apb_regs (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [ddsr_pkg::ADDR_W-1:0]  paddr,
	input  wire logic [ddsr_pkg::DATA_W-1:0]  pwdata,
	output logic      [ddsr_pkg::DATA_W-1:0]  prdata,
	output logic                               pready,
	output logic      [ddsr_pkg::REG_W-1:0]   body_rad,
	output logic      [ddsr_pkg::REG_W-1:0]   wheel_rad
);

	logic [ddsr_pkg::REG_W-1:0] body_q;
	logic [ddsr_pkg::REG_W-1:0] wheel_q;
	ddsr_pkg::reg_idx_t         reg_idx;

	// Byte offset picks the register; the low address bits are ignored
	assign reg_idx = ddsr_pkg::reg_idx_t'(paddr[2]);
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			body_q  <= ddsr_pkg::BODY_RESET;
			wheel_q <= ddsr_pkg::WHEEL_RESET;
		end else if (psel && penable && pwrite) begin
			case (reg_idx)
				ddsr_pkg::REG_BODY:  body_q  <= pwdata[ddsr_pkg::REG_W-1:0];
				ddsr_pkg::REG_WHEEL: wheel_q <= pwdata[ddsr_pkg::REG_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			ddsr_pkg::REG_BODY:  prdata = ddsr_pkg::DATA_W'(body_q);
			ddsr_pkg::REG_WHEEL: prdata = ddsr_pkg::DATA_W'(wheel_q);
			default:             prdata = '0;
		endcase
	end

	assign body_rad  = body_q;
	assign wheel_rad = wheel_q;

endmodule

`default_nettype wire

// ----- hdl/ddsr_kin.sv -----
`default_nettype none

module ddsr_kin (
	input  wire logic                                 clk,
	input  wire logic                                 adv,
	input  wire logic signed [ddsr_pkg::LIN_W-1:0]   linear_mm_s,
	input  wire logic signed [ddsr_pkg::ANG_W-1:0]   angular_mrad_s,
	input  wire logic        [ddsr_pkg::REG_W-1:0]   body_rad,
	input  wire logic        [ddsr_pkg::REG_W-1:0]   wheel_rad,
	output ddsr_pkg::wheel_t                          right_s8,
	output ddsr_pkg::wheel_t                          left_s8,
	output logic             [ddsr_pkg::NH_W-1:0]    nh_s8
);

	// Stage 1: scale linear speed, split off the turn sign
	logic signed [ddsr_pkg::BASE_W-1:0]    base_s1;
	logic                                  neg_s1;
	logic        [ddsr_pkg::ANG_MAG_W-1:0] mag_s1;
	logic        [ddsr_pkg::ANG_MAG_W-1:0] ang_mag;

	// Stage 2: |angular| / 1000
	logic signed [ddsr_pkg::BASE_W-1:0]    base_s2;
	logic                                  neg_s2;
	logic        [ddsr_pkg::ANG_MAG_W-1:0] mag_s2;
	logic        [ddsr_pkg::AH_W-1:0]      ah_s2;
	logic        [ddsr_pkg::AH_PROD_W-1:0] ah_prod;

	// Stage 3: remainder and high partial turn
	logic signed [ddsr_pkg::BASE_W-1:0] base_s3;
	logic                               neg_s3;
	logic        [ddsr_pkg::AL_W-1:0]   al_s3;
	logic        [ddsr_pkg::HI_W-1:0]   hi_s3;
	logic        [ddsr_pkg::ANG_MAG_W-1:0] al_full;

	// Stage 4: low partial product
	logic signed [ddsr_pkg::BASE_W-1:0] base_s4;
	logic                               neg_s4;
	logic        [ddsr_pkg::HI_W-1:0]   hi_s4;
	logic        [ddsr_pkg::P_W-1:0]    p_s4;

	// Stage 5: low partial product / 1000
	logic signed [ddsr_pkg::BASE_W-1:0]    base_s5;
	logic                                  neg_s5;
	logic        [ddsr_pkg::HI_W-1:0]      hi_s5;
	logic        [ddsr_pkg::LO_W-1:0]      lo_s5;
	logic        [ddsr_pkg::LO_PROD_W-1:0] lo_prod;

	// Stage 6: turn magnitude
	logic signed [ddsr_pkg::BASE_W-1:0] base_s6;
	logic                               neg_s6;
	logic        [ddsr_pkg::T_W-1:0]    t_s6;

	// Stage 7: signed rim speeds
	logic signed [ddsr_pkg::RIM_W-1:0] rim_r_s7;
	logic signed [ddsr_pkg::RIM_W-1:0] rim_l_s7;
	logic signed [ddsr_pkg::RIM_W-1:0] base_x;
	logic signed [ddsr_pkg::RIM_W-1:0] t_x;

	logic [ddsr_pkg::NH_PROD_W-1:0] nh_prod;

	assign ang_mag = angular_mrad_s[ddsr_pkg::ANG_W-1]
		? ddsr_pkg::ANG_MAG_W'(-angular_mrad_s)
		: ddsr_pkg::ANG_MAG_W'(angular_mrad_s);

	assign ah_prod = ddsr_pkg::AH_PROD_W'(mag_s1) * ddsr_pkg::AH_RECIP;

	assign al_full = mag_s2 - ddsr_pkg::ANG_MAG_W'(ah_s2) * ddsr_pkg::ANG_THOUSAND;

	assign lo_prod = ddsr_pkg::LO_PROD_W'(p_s4) * ddsr_pkg::LO_RECIP;

	assign base_x = ddsr_pkg::RIM_W'(base_s6);
	assign t_x    = signed'({1'b0, t_s6});

	assign nh_prod = ddsr_pkg::NH_PROD_W'(wheel_rad) * ddsr_pkg::RATE_Q16;

	always_ff @(posedge clk) begin
		if (adv) begin
			base_s1 <= ddsr_pkg::BASE_W'(linear_mm_s) * ddsr_pkg::MM_TO_UM;
			neg_s1  <= angular_mrad_s[ddsr_pkg::ANG_W-1];
			mag_s1  <= ang_mag;

			base_s2 <= base_s1;
			neg_s2  <= neg_s1;
			mag_s2  <= mag_s1;
			ah_s2   <= ah_prod[ddsr_pkg::AH_SHIFT +: ddsr_pkg::AH_W];

			base_s3 <= base_s2;
			neg_s3  <= neg_s2;
			al_s3   <= al_full[ddsr_pkg::AL_W-1:0];
			hi_s3   <= ddsr_pkg::HI_W'(body_rad) * ddsr_pkg::HI_W'(ah_s2);

			base_s4 <= base_s3;
			neg_s4  <= neg_s3;
			hi_s4   <= hi_s3;
			p_s4    <= ddsr_pkg::P_W'(body_rad) * ddsr_pkg::P_W'(al_s3);

			base_s5 <= base_s4;
			neg_s5  <= neg_s4;
			hi_s5   <= hi_s4;
			lo_s5   <= lo_prod[ddsr_pkg::LO_SHIFT +: ddsr_pkg::LO_W];

			base_s6 <= base_s5;
			neg_s6  <= neg_s5;
			t_s6    <= ddsr_pkg::T_W'(hi_s5) + ddsr_pkg::T_W'(lo_s5);

			// Right wheel adds the turn, left subtracts it
			rim_r_s7 <= neg_s6 ? base_x - t_x : base_x + t_x;
			rim_l_s7 <= neg_s6 ? base_x + t_x : base_x - t_x;

			right_s8.mag     <= rim_r_s7[ddsr_pkg::RIM_W-1]
				? ddsr_pkg::MAG_W'(-rim_r_s7) : ddsr_pkg::MAG_W'(rim_r_s7);
			right_s8.forward <= !rim_r_s7[ddsr_pkg::RIM_W-1];
			right_s8.nonzero <= |rim_r_s7;
			left_s8.mag      <= rim_l_s7[ddsr_pkg::RIM_W-1]
				? ddsr_pkg::MAG_W'(-rim_l_s7) : ddsr_pkg::MAG_W'(rim_l_s7);
			left_s8.forward  <= !rim_l_s7[ddsr_pkg::RIM_W-1];
			left_s8.nonzero  <= |rim_l_s7;
			nh_s8            <= nh_prod[ddsr_pkg::NH_SHIFT +: ddsr_pkg::NH_W];
		end
	end

endmodule

`default_nettype wire

// ----- hdl/ddsr_div.sv -----
`default_nettype none

module ddsr_div (
	input  wire logic                          clk,
	input  wire logic                          adv,
	input  wire ddsr_pkg::wheel_t              wheel_in,
	input  wire logic [ddsr_pkg::NH_W-1:0]    nh_in,
	output ddsr_pkg::wheel_res_t               res_q
);

	// Index 0 is the saturation stage; index k+1 holds quotient bit k done
	logic [ddsr_pkg::NH_W-1:0]  rem_s  [0:ddsr_pkg::CMP_W];
	logic [ddsr_pkg::MAG_W-1:0] mag_s  [0:ddsr_pkg::CMP_W];
	logic [ddsr_pkg::CMP_W-1:0] quo_s  [0:ddsr_pkg::CMP_W];
	logic                       fwd_s  [0:ddsr_pkg::CMP_W];
	logic                       nz_s   [0:ddsr_pkg::CMP_W];
	logic                       sat_s  [0:ddsr_pkg::CMP_W];

	logic [ddsr_pkg::DIV_W-1:0] trial  [0:ddsr_pkg::CMP_W-1];
	logic                       take   [0:ddsr_pkg::CMP_W-1];
	logic                       sat_in;
	logic [ddsr_pkg::CMP_W-1:0] q_fin;

	// Quotient above the compare range iff numerator >= mag * 2^CMP_W
	assign sat_in = ddsr_pkg::DIV_W'(nh_in) >= {wheel_in.mag, ddsr_pkg::CMP_W'(0)};

	always_comb begin
		for (int k = 0; k < ddsr_pkg::CMP_W; k++) begin
			trial[k] = ddsr_pkg::DIV_W'(mag_s[k]) << (ddsr_pkg::CMP_W - 1 - k);
			take[k]  = ddsr_pkg::DIV_W'(rem_s[k]) >= trial[k];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rem_s[0] <= nh_in;
			mag_s[0] <= wheel_in.mag;
			quo_s[0] <= '0;
			fwd_s[0] <= wheel_in.forward;
			nz_s[0]  <= wheel_in.nonzero;
			sat_s[0] <= sat_in;
			// Restoring division, one quotient bit per stage, MSB first
			for (int k = 0; k < ddsr_pkg::CMP_W; k++) begin
				rem_s[k+1] <= take[k] ? rem_s[k] - trial[k][ddsr_pkg::NH_W-1:0] : rem_s[k];
				mag_s[k+1] <= mag_s[k];
				quo_s[k+1] <= {quo_s[k][ddsr_pkg::CMP_W-2:0], take[k]};
				fwd_s[k+1] <= fwd_s[k];
				nz_s[k+1]  <= nz_s[k];
				sat_s[k+1] <= sat_s[k];
			end
		end
	end

	assign q_fin = quo_s[ddsr_pkg::CMP_W];

	// Zero rim speed disables; saturation clamps to full scale
	always_ff @(posedge clk) begin
		if (adv) begin
			res_q.forward <= fwd_s[ddsr_pkg::CMP_W];
			if (!nz_s[ddsr_pkg::CMP_W]) begin
				res_q.compare   <= '0;
				res_q.enable    <= 1'b0;
				res_q.saturated <= 1'b0;
			end else if (sat_s[ddsr_pkg::CMP_W]) begin
				res_q.compare   <= ddsr_pkg::CMP_MAX;
				res_q.enable    <= 1'b1;
				res_q.saturated <= 1'b1;
			end else begin
				res_q.compare   <= q_fin;
				res_q.enable    <= |q_fin;
				res_q.saturated <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

// ----- sim/diff_drive_step_rate_top_test.sv -----
`timescale 1ns / 100ps

module diff_drive_step_rate_top_test;

	localparam int CYCLE_LIMIT  = 200000;
	localparam int SETTLE_CYCLES = ddsr_pkg::PIPE_DEPTH + 6;
	localparam longint unsigned STEP_Q16 = 64'd4021239;

	typedef struct packed {
		logic [ddsr_pkg::CMP_W-1:0] right_compare;
		logic                       right_forward;
		logic                       right_enable;
		logic [ddsr_pkg::CMP_W-1:0] left_compare;
		logic                       left_forward;
		logic                       left_enable;
		logic                       rate_saturated;
	} drive_rate_t;

	logic clk;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [ddsr_pkg::ADDR_W-1:0] paddr;
	logic [ddsr_pkg::DATA_W-1:0] pwdata;
	logic [ddsr_pkg::DATA_W-1:0] prdata;
	logic pready;

	ddsr_cmd_if cmd_bus ();
	ddsr_res_if res_bus ();

	diff_drive_step_rate_top DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd_bus),
		.res     (res_bus),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// Radii as the block should hold them
	logic [ddsr_pkg::REG_W-1:0] body_um;
	logic [ddsr_pkg::REG_W-1:0] wheel_um;

	drive_rate_t rate_queue[$];
	bit idle_on = 1'b1;
	int cycle_count;
	int mismatches;
	int cmds_sent;
	int results_checked;
	int radius_settings;
	int saturated_seen;
	int disabled_seen;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		cycle_count = 0;
		forever begin
			@(posedge clk);
			cycle_count++;
			if (cycle_count > CYCLE_LIMIT) begin
				$display("Timeout after %0d cycles, %0d results outstanding",
					cycle_count, rate_queue.size());
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	function automatic ddsr_pkg::wheel_res_t wheel_rate_of(longint rim);
		longint unsigned mag;
		longint unsigned quot;
		ddsr_pkg::wheel_res_t w;
		w = '0;
		w.forward = (rim >= 0);
		if (rim != 0) begin
			mag = (rim < 0) ? -rim : rim;
			quot = (STEP_Q16 * {44'd0, wheel_um}) / (mag << 16);
			if (quot != 0) begin
				w.enable = 1'b1;
				if (quot > 64'd255) begin
					w.compare = ddsr_pkg::CMP_MAX;
					w.saturated = 1'b1;
				end else begin
					w.compare = quot[ddsr_pkg::CMP_W-1:0];
				end
			end
		end
		return w;
	endfunction

	function automatic drive_rate_t predict_rate(logic signed [ddsr_pkg::LIN_W-1:0] lin,
			logic signed [ddsr_pkg::ANG_W-1:0] ang);
		longint base;
		longint turn;
		ddsr_pkg::wheel_res_t r;
		ddsr_pkg::wheel_res_t l;
		drive_rate_t p;
		base = longint'(lin) * 1000;
		// signed divide truncates toward zero
		turn = (longint'({44'd0, body_um}) * longint'(ang)) / 1000;
		r = wheel_rate_of(base + turn);
		l = wheel_rate_of(base - turn);
		p.right_compare  = r.compare;
		p.right_forward  = r.forward;
		p.right_enable   = r.enable;
		p.left_compare   = l.compare;
		p.left_forward   = l.forward;
		p.left_enable    = l.enable;
		p.rate_saturated = r.saturated | l.saturated;
		return p;
	endfunction

	task automatic send_cmd(logic signed [ddsr_pkg::LIN_W-1:0] lin,
			logic signed [ddsr_pkg::ANG_W-1:0] ang);
		int gap;
		if (idle_on && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 4);
			cmd_bus.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_bus.valid <= 1'b1;
		cmd_bus.linear_mm_s <= lin;
		cmd_bus.angular_mrad_s <= ang;
		do @(posedge clk); while (!cmd_bus.ready);
		rate_queue.push_back(predict_rate(lin, ang));
		cmds_sent++;
	endtask

	// Hold off commands until every result is back
	task automatic drain_results();
		cmd_bus.valid <= 1'b0;
		while (rate_queue.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_radius(ddsr_pkg::reg_idx_t idx, logic [ddsr_pkg::REG_W-1:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= {{(ddsr_pkg::DATA_W-ddsr_pkg::REG_W){1'b0}}, value};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		case (idx)
			ddsr_pkg::REG_BODY: body_um = value;
			ddsr_pkg::REG_WHEEL: wheel_um = value;
			default: ;
		endcase
	endtask

	task automatic set_radii(logic [ddsr_pkg::REG_W-1:0] body,
			logic [ddsr_pkg::REG_W-1:0] wheel);
		drain_results();
		write_radius(ddsr_pkg::REG_BODY, body);
		write_radius(ddsr_pkg::REG_WHEEL, wheel);
		radius_settings++;
	endtask

	task automatic rand_cmd(output logic signed [ddsr_pkg::LIN_W-1:0] lin,
			output logic signed [ddsr_pkg::ANG_W-1:0] ang);
		int v;
		int w;
		case ($urandom_range(0, 3))
			0: begin
				v = $urandom;
				w = $urandom;
			end
			1: begin
				v = int'($urandom_range(0, 4000)) - 2000;
				w = int'($urandom_range(0, 40000)) - 20000;
			end
			2: begin
				v = int'($urandom_range(0, 40)) - 20;
				w = int'($urandom_range(0, 400)) - 200;
			end
			default: begin
				// straight run or turn in place
				if ($urandom_range(0, 1) == 0) begin
					v = 0;
					w = $urandom;
				end else begin
					v = $urandom;
					w = 0;
				end
			end
		endcase
		lin = v[ddsr_pkg::LIN_W-1:0];
		ang = w[ddsr_pkg::ANG_W-1:0];
	endtask

	task automatic send_random(int count);
		logic signed [ddsr_pkg::LIN_W-1:0] lin;
		logic signed [ddsr_pkg::ANG_W-1:0] ang;
		for (int i = 0; i < count; i++) begin
			rand_cmd(lin, ang);
			send_cmd(lin, ang);
		end
	endtask

	task automatic test_reset_defaults();
		send_cmd(12'sd0, 16'sd0);
		send_cmd(12'sd500, 16'sd0);
		send_cmd(12'sd0, 16'sd2000);
		send_cmd(-12'sd300, -16'sd1500);
	endtask

	task automatic test_field_extremes();
		send_cmd(12'sd2047, 16'sd32767);
		send_cmd(-12'sd2048, -16'sd32768);
		send_cmd(12'sd2047, -16'sd32768);
		send_cmd(-12'sd2048, 16'sd32767);
		send_cmd(12'sd2000, 16'sd20000);
		send_cmd(-12'sd2000, -16'sd20000);
		send_cmd(12'sd1, 16'sd0);
		send_cmd(-12'sd1, 16'sd0);
	endtask

	task automatic test_special_cases();
		// one wheel at zero rim speed, the other moving
		send_cmd(12'sd126, 16'sd1000);
		send_cmd(-12'sd126, -16'sd1000);
		// turn term that does not divide evenly
		set_radii(20'd126543, ddsr_pkg::WHEEL_RESET);
		send_cmd(12'sd0, -16'sd7);
		send_cmd(12'sd0, 16'sd7);
		// quotient truncates to zero
		set_radii(ddsr_pkg::BODY_RESET, 20'd1);
		send_cmd(12'sd2000, 16'sd0);
		send_cmd(-12'sd2000, 16'sd0);
		// zero wheel radius
		set_radii(ddsr_pkg::BODY_RESET, 20'd0);
		send_cmd(12'sd100, 16'sd300);
		send_cmd(-12'sd5, 16'sd0);
		// compare clamped
		set_radii(ddsr_pkg::BODY_RESET, ddsr_pkg::WHEEL_RESET);
		send_cmd(12'sd1, 16'sd0);
		send_cmd(-12'sd1, 16'sd1);
	endtask

	task automatic test_register_extremes();
		logic [ddsr_pkg::REG_W-1:0] ext_body [9] = '{20'd0, 20'd0, 20'd1000000,
			20'd1000000, 20'hFFFFF, 20'hFFFFF, 20'd0, 20'h55555, 20'hAAAAA};
		logic [ddsr_pkg::REG_W-1:0] ext_wheel [9] = '{20'd1, 20'd1000000, 20'd1,
			20'd1000000, 20'hFFFFF, 20'd0, 20'h80000, 20'hAAAAA, 20'h55555};
		for (int s = 0; s < 9; s++) begin
			set_radii(ext_body[s], ext_wheel[s]);
			send_random(10);
		end
	endtask

	task automatic test_random_commands();
		logic [ddsr_pkg::REG_W-1:0] body;
		logic [ddsr_pkg::REG_W-1:0] wheel;
		for (int ph = 0; ph < 9; ph++) begin
			if ($urandom_range(0, 1) == 0) begin
				body = ddsr_pkg::REG_W'($urandom_range(0, 1000000));
				wheel = ddsr_pkg::REG_W'($urandom_range(1, 1000000));
			end else begin
				body = ddsr_pkg::REG_W'($urandom);
				wheel = ddsr_pkg::REG_W'($urandom);
			end
			set_radii(body, wheel);
			send_random(67);
			drain_results();
			send_random(68);
		end
	endtask

	task automatic test_back_to_back();
		set_radii(ddsr_pkg::BODY_RESET, ddsr_pkg::WHEEL_RESET);
		idle_on = 1'b0;
		send_random(150);
	endtask

	// Result side: check each transfer, stall ready in short bursts
	initial begin
		drive_rate_t got;
		drive_rate_t want;
		int stall_left;
		stall_left = 0;
		res_bus.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && res_bus.valid && res_bus.ready) begin
				got.right_compare  = res_bus.right_compare;
				got.right_forward  = res_bus.right_forward;
				got.right_enable   = res_bus.right_enable;
				got.left_compare   = res_bus.left_compare;
				got.left_forward   = res_bus.left_forward;
				got.left_enable    = res_bus.left_enable;
				got.rate_saturated = res_bus.rate_saturated;
				if (rate_queue.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("Unexpected result at cycle %0d: %p", cycle_count, got);
				end else begin
					want = rate_queue.pop_front();
					results_checked++;
					if (want.rate_saturated) saturated_seen++;
					if (!want.right_enable || !want.left_enable) disabled_seen++;
					if (got !== want) begin
						mismatches++;
						if (mismatches <= 10) begin
							$display("Mismatch on result %0d at cycle %0d",
								results_checked, cycle_count);
							$display("  expected R cmp=%0d fwd=%b en=%b L cmp=%0d fwd=%b en=%b sat=%b",
								want.right_compare, want.right_forward, want.right_enable,
								want.left_compare, want.left_forward, want.left_enable,
								want.rate_saturated);
							$display("  actual   R cmp=%0d fwd=%b en=%b L cmp=%0d fwd=%b en=%b sat=%b",
								got.right_compare, got.right_forward, got.right_enable,
								got.left_compare, got.left_forward, got.left_enable,
								got.rate_saturated);
						end
					end
				end
			end
			if (stall_left > 0) begin
				stall_left--;
				res_bus.ready <= 1'b0;
			end else if (idle_on && $urandom_range(0, 5) == 0) begin
				stall_left = $urandom_range(1, 4) - 1;
				res_bus.ready <= 1'b0;
			end else begin
				res_bus.ready <= 1'b1;
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		cmd_bus.valid = 1'b0;
		cmd_bus.linear_mm_s = '0;
		cmd_bus.angular_mrad_s = '0;
		body_um = ddsr_pkg::BODY_RESET;
		wheel_um = ddsr_pkg::WHEEL_RESET;
		mismatches = 0;
		cmds_sent = 0;
		results_checked = 0;
		radius_settings = 1;
		saturated_seen = 0;
		disabled_seen = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_field_extremes();
		test_special_cases();
		test_register_extremes();
		test_random_commands();
		test_back_to_back();

		cmd_bus.valid <= 1'b0;
		while (rate_queue.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Checked %0d results for %0d commands over %0d radius settings",
			results_checked, cmds_sent, radius_settings);
		$display("Expected %0d clamped rates and %0d results with a wheel disabled",
			saturated_seen, disabled_seen);
		if (mismatches == 0 && rate_queue.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
